// File: rtl/assert_macros.svh
// Assertion macros used by the life block controller RTL.
// Needs nothing; each macro expands to one concurrent assertion or to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LCA_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCA_ASSERT(lbl, clk, rstn, prop, msg)
`define LCA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/lca_pkg.sv
// Shared types and constants of the life block: grid size, opcodes,
// payload structs and the controller/datapath command and status bundles.
package lca_pkg;

	localparam int GRID_ROWS = 128;
	localparam int GRID_COLS = 128;

	localparam int COORD_W   = 10;
	localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int CNT_W     = $clog2(GRID_ROWS + 1);
	localparam int ADDR_W    = ROW_W + 1;
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_STEP = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} item_t;

	typedef struct packed {
		logic cell_alive;
		logic out_of_range;
	} result_t;

	typedef struct packed {
		logic capture;
		logic rd_item;
		logic modify;
		logic step_init;
		logic step_issue;
		logic flip;
		logic clr_write;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic step_last;
		logic op_set;
		logic op_read;
		logic op_step;
		logic in_grid;
	} status_t;

endpackage

// File: rtl/life_cellular_automaton.sv
// Game of Life (B3/S23) grid of lca_pkg::GRID_ROWS x GRID_COLS cells with a dead border.
// Top level; uses lca_pkg, lca_ctrl and lca_datapath.
//
// One item is taken at a time and gives one result. After reset bank 0 of the
// grid RAM is cleared one row per cycle, and item_stall stays high until that
// pass is done. A set or read in range passes through DECODE, MODIFY and RESULT
// before the result register is loaded; an out-of-range access or unused opcode
// skips MODIFY. A generation step sweeps the grid one full row per cycle through
// a three-row window and writes the new generation into the other RAM bank,
// which becomes the active bank in STEP_END. The next item is accepted while a
// finished result still waits in the output register.
module life_cellular_automaton (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lca_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output lca_pkg::result_t  result
);

	lca_pkg::cmd_t    cmd;
	lca_pkg::status_t status;

	lca_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	lca_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.result (result)
	);

endmodule

// File: rtl/lca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module lca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/lca_datapath.sv
// Datapath of the life block: item and result registers, row counter,
// three-row window with the B3/S23 row update, and the double-banked grid RAM.
// Uses lca_pkg and lca_ram.
module lca_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lca_pkg::cmd_t     cmd,
	output lca_pkg::status_t  status,
	input  lca_pkg::item_t    item,
	output lca_pkg::result_t  result
);

	localparam int COLS = lca_pkg::GRID_COLS;

	lca_pkg::item_t   item_q;
	lca_pkg::result_t res_q;
	lca_pkg::result_t out_q;

	logic                        bank_q;
	logic [lca_pkg::CNT_W-1:0]   cnt_q;

	logic                        valid_s1;
	logic                        zero_s1;
	logic [lca_pkg::CNT_W-1:0]   k_s1;

	logic [COLS-1:0]             upper_q;
	logic [COLS-1:0]             mid_q;
	logic [COLS-1:0]             lower;
	logic [COLS-1:0]             next_row;

	logic                        we;
	logic [lca_pkg::ADDR_W-1:0]  waddr;
	logic [COLS-1:0]             wdata;
	logic                        re;
	logic [lca_pkg::ADDR_W-1:0]  raddr;
	logic [COLS-1:0]             rdata;

	logic                        new_in_grid;
	logic                        new_oor;
	logic                        q_in_grid;
	logic [lca_pkg::ROW_W-1:0]   q_row;
	logic [lca_pkg::COL_W-1:0]   q_col;
	logic [lca_pkg::CNT_W-1:0]   k_prev;

	function automatic logic coord_ok(logic [lca_pkg::COORD_W-1:0] r,
	                                  logic [lca_pkg::COORD_W-1:0] c);
		coord_ok = ({1'b0, r} < (lca_pkg::COORD_W + 1)'(lca_pkg::GRID_ROWS)) &&
		           ({1'b0, c} < (lca_pkg::COORD_W + 1)'(lca_pkg::GRID_COLS));
	endfunction

	assign new_in_grid = coord_ok(item.row, item.col);
	assign new_oor     = !new_in_grid &&
	                     (item.operation == lca_pkg::OP_SET ||
	                      item.operation == lca_pkg::OP_READ);
	assign q_in_grid   = coord_ok(item_q.row, item_q.col);
	assign q_row       = item_q.row[lca_pkg::ROW_W-1:0];
	assign q_col       = item_q.col[lca_pkg::COL_W-1:0];
	assign k_prev      = k_s1 - 1'b1;

	assign status.clr_last  = (cnt_q == lca_pkg::CNT_W'(lca_pkg::GRID_ROWS - 1));
	assign status.step_last = (cnt_q == lca_pkg::CNT_W'(lca_pkg::GRID_ROWS));
	assign status.op_set    = (item_q.operation == lca_pkg::OP_SET);
	assign status.op_read   = (item_q.operation == lca_pkg::OP_READ);
	assign status.op_step   = (item_q.operation == lca_pkg::OP_STEP);
	assign status.in_grid   = q_in_grid;

	assign result = out_q;

	// bottom row of the window; below the last grid row everything is dead
	assign lower = zero_s1 ? '0 : rdata;

	always_comb begin
		logic [COLS+1:0] up_p;
		logic [COLS+1:0] md_p;
		logic [COLS+1:0] lo_p;
		logic [3:0]      n;
		up_p = {1'b0, upper_q, 1'b0};
		md_p = {1'b0, mid_q, 1'b0};
		lo_p = {1'b0, lower, 1'b0};
		for (int c = 0; c < COLS; c++) begin
			n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2]) +
			    4'(md_p[c]) + 4'(md_p[c+2]) +
			    4'(lo_p[c]) + 4'(lo_p[c+1]) + 4'(lo_p[c+2]);
			next_row[c] = (n == 4'd3) || (md_p[c+1] && n == 4'd2);
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = {bank_q, q_row};
		wdata = rdata | (COLS'(1) << q_col);
		if (cmd.clr_write) begin
			we    = 1'b1;
			waddr = {1'b0, cnt_q[lca_pkg::ROW_W-1:0]};
			wdata = '0;
		end else if (cmd.modify && status.op_set) begin
			we = 1'b1;
		end else if (valid_s1 && k_s1 != '0) begin
			we    = 1'b1;
			waddr = {!bank_q, k_prev[lca_pkg::ROW_W-1:0]};
			wdata = next_row;
		end
	end

	always_comb begin
		re    = cmd.rd_item || cmd.step_issue;
		raddr = cmd.step_issue ? {bank_q, cnt_q[lca_pkg::ROW_W-1:0]} : {bank_q, q_row};
	end

	lca_ram #(
		.WIDTH(COLS),
		.DEPTH(lca_pkg::RAM_DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step_issue;
			if (cmd.step_init) begin
				cnt_q <= '0;
			end else if (cmd.clr_write || cmd.step_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.flip) begin
				bank_q <= !bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1    <= cnt_q;
		zero_s1 <= status.step_last;
		if (cmd.capture) begin
			item_q <= item;
			res_q  <= '{cell_alive: 1'b0, out_of_range: new_oor};
		end
		if (cmd.modify && status.op_read) begin
			res_q.cell_alive <= rdata[q_col];
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
		if (cmd.step_init) begin
			upper_q <= '0;
			mid_q   <= '0;
		end else if (valid_s1) begin
			upper_q <= mid_q;
			mid_q   <= lower;
		end
	end

endmodule

// File: rtl/lca_ctrl.sv
// Controller of the life block: sequences clearing, set/read access,
// the generation sweep and the result handoff. Uses lca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  lca_pkg::status_t  status,
	output lca_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		DECODE,
		MODIFY,
		STEP,
		STEP_END,
		RESULT
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   slot_free;

	assign slot_free    = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == IDLE) && item_valid;
		cmd.rd_item    = (state_q == DECODE);
		cmd.step_init  = (state_q == DECODE);
		cmd.modify     = (state_q == MODIFY);
		cmd.step_issue = (state_q == STEP);
		cmd.flip       = (state_q == STEP_END);
		cmd.clr_write  = (state_q == CLEAR);
		cmd.load_out   = (state_q == RESULT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= CLEAR;
			result_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				CLEAR: begin
					if (status.clr_last) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (item_valid) begin
						state_q <= DECODE;
					end
				end
				DECODE: begin
					if (status.op_step) begin
						state_q <= STEP;
					end else if ((status.op_set || status.op_read) && status.in_grid) begin
						state_q <= MODIFY;
					end else begin
						state_q <= RESULT;
					end
				end
				MODIFY: begin
					state_q <= RESULT;
				end
				STEP: begin
					if (status.step_last) begin
						state_q <= STEP_END;
					end
				end
				STEP_END: begin
					state_q <= RESULT;
				end
				RESULT: begin
					if (slot_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`LCA_ASSERT(a_step_full_sweep, clk, arst_n, (state_q == STEP_END) |-> $past(status.step_last), "sweep ended before last row")
	`LCA_ASSERT(a_load_free_slot, clk, arst_n, cmd.load_out |-> (!result_valid_q || !result_stall), "result overwritten while pending")
	`LCA_ASSERT(a_modify_after_decode, clk, arst_n, (state_q == MODIFY) |-> ($past(state_q) == DECODE), "cell access without decode")
	`LCA_ASSERT(a_valid_from_result, clk, arst_n, $rose(result_valid_q) |-> ($past(state_q) == RESULT), "result raised outside handoff")

endmodule

// File: bench/life_cellular_automaton_test.sv
// Self-checking regression for the life_cellular_automaton block.
// Uses lca_pkg; keeps a local copy of the grid to predict every result, then
// drives directed, random and back-pressure traffic over the valid/stall channels.
`timescale 1ns / 1ps

module life_cellular_automaton_test;

	localparam logic [1:0] OP_NONE   = 2'd3;
	localparam int         LONG_HOLD = 300;
	localparam int         MAX_CYCLES = 300000;
	localparam int         WIN       = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid;
	logic             item_stall;
	lca_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall = 1'b0;
	lca_pkg::result_t result;

	life_cellular_automaton dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Predicted grid state
	bit live [lca_pkg::GRID_ROWS][lca_pkg::GRID_COLS];
	bit next_live [lca_pkg::GRID_ROWS][lca_pkg::GRID_COLS];

	lca_pkg::result_t pending_results [$];
	int      error_count = 0;
	int      cycle_count = 0;
	bit      quiet_tail = 1'b0;
	bit      hold_request = 1'b0;
	int      stall_left = 0;
	int      win_r = 0;
	int      win_c = 0;

	function automatic bit live_at(int r, int c);
		if (r < 0 || r >= lca_pkg::GRID_ROWS || c < 0 || c >= lca_pkg::GRID_COLS)
			return 1'b0;
		return live[r][c];
	endfunction

	function automatic void advance_generation();
		int n;
		for (int r = 0; r < lca_pkg::GRID_ROWS; r++) begin
			for (int c = 0; c < lca_pkg::GRID_COLS; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							n += live_at(r + dr, c + dc);
				if (live[r][c])
					next_live[r][c] = (n == 2 || n == 3);
				else
					next_live[r][c] = (n == 3);
			end
		end
		live = next_live;
	endfunction

	function automatic lca_pkg::result_t apply_life_op(lca_pkg::item_t it);
		lca_pkg::result_t r;
		bit               in_grid;
		r = '0;
		in_grid = (it.row < lca_pkg::GRID_ROWS) && (it.col < lca_pkg::GRID_COLS);
		case (it.operation)
			lca_pkg::OP_SET: begin
				if (in_grid)
					live[it.row][it.col] = 1'b1;
				else
					r.out_of_range = 1'b1;
			end
			lca_pkg::OP_STEP: begin
				advance_generation();
			end
			lca_pkg::OP_READ: begin
				if (in_grid)
					r.cell_alive = live[it.row][it.col];
				else
					r.out_of_range = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic lca_pkg::item_t build_item(logic [1:0] op, int r, int c);
		lca_pkg::item_t it;
		it.operation = op;
		it.row = r[lca_pkg::COORD_W-1:0];
		it.col = c[lca_pkg::COORD_W-1:0];
		return it;
	endfunction

	// Called at a rising edge; returns at the edge where the transaction was taken.
	task automatic send_item(lca_pkg::item_t it);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(apply_life_op(it));
	endtask

	task automatic send_op(logic [1:0] op, int r, int c);
		send_item(build_item(op, r, c));
	endtask

	// Sender goes quiet until every predicted result has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic pick_window();
		case ($urandom_range(0, 2))
			0: win_r = 0;
			1: win_r = lca_pkg::GRID_ROWS - WIN;
			default: win_r = $urandom_range(0, lca_pkg::GRID_ROWS - WIN);
		endcase
		case ($urandom_range(0, 2))
			0: win_c = 0;
			1: win_c = lca_pkg::GRID_COLS - WIN;
			default: win_c = $urandom_range(0, lca_pkg::GRID_COLS - WIN);
		endcase
	endtask

	// Mostly sets and reads clustered in a small window so patterns evolve,
	// with occasional steps and some fully random noise.
	task automatic send_random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			send_op(lca_pkg::OP_SET, win_r + $urandom_range(0, WIN - 1),
				win_c + $urandom_range(0, WIN - 1));
		else if (sel < 75)
			send_op(lca_pkg::OP_READ, win_r + $urandom_range(0, WIN - 1),
				win_c + $urandom_range(0, WIN - 1));
		else if (sel < 87)
			send_op(lca_pkg::OP_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023));
		else
			send_op(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
				$urandom_range(0, 1023));
	endtask

	task automatic test_corners_and_bounds();
		send_op(lca_pkg::OP_SET, 0, 0);
		send_op(lca_pkg::OP_SET, 0, lca_pkg::GRID_COLS - 1);
		send_op(lca_pkg::OP_SET, lca_pkg::GRID_ROWS - 1, 0);
		send_op(lca_pkg::OP_SET, lca_pkg::GRID_ROWS - 1, lca_pkg::GRID_COLS - 1);
		send_op(lca_pkg::OP_READ, 0, 0);
		send_op(lca_pkg::OP_READ, 0, lca_pkg::GRID_COLS - 1);
		send_op(lca_pkg::OP_READ, lca_pkg::GRID_ROWS - 1, 0);
		send_op(lca_pkg::OP_READ, lca_pkg::GRID_ROWS - 1, lca_pkg::GRID_COLS - 1);
		send_op(lca_pkg::OP_READ, 1, 1);
		send_op(lca_pkg::OP_SET, lca_pkg::GRID_ROWS, 0);
		send_op(lca_pkg::OP_SET, 0, lca_pkg::GRID_COLS);
		send_op(lca_pkg::OP_SET, 1023, 1023);
		send_op(lca_pkg::OP_READ, 1023, 0);
		send_op(lca_pkg::OP_READ, 0, 1023);
	endtask

	// Unused opcode and a step whose coordinate fields must be ignored
	task automatic test_unused_op_and_step();
		send_op(OP_NONE, 1023, 1023);
		send_op(OP_NONE, 0, 0);
		send_op(lca_pkg::OP_STEP, 1023, 1023);
		send_op(lca_pkg::OP_READ, 0, 0);
	endtask

	// Vertical blinker against the left edge: cells beyond the border are dead
	task automatic test_blinker_at_border();
		send_op(lca_pkg::OP_SET, 0, 0);
		send_op(lca_pkg::OP_SET, 1, 0);
		send_op(lca_pkg::OP_SET, 2, 0);
		send_op(lca_pkg::OP_STEP, 0, 0);
		send_op(lca_pkg::OP_READ, 1, 0);
		send_op(lca_pkg::OP_READ, 1, 1);
		send_op(lca_pkg::OP_READ, 0, 0);
	endtask

	task automatic test_random_traffic(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0)
				pick_window();
			send_random_item();
		end
	endtask

	// Receiver holds off for a long stretch while items keep coming
	task automatic test_backpressure();
		hold_request = 1'b1;
		pick_window();
		for (int i = 0; i < 12; i++)
			send_random_item();
		drain_results();
		for (int i = 0; i < 6; i++)
			send_random_item();
	endtask

	task automatic test_no_idle_tail();
		drain_results();
		quiet_tail = 1'b1;
		test_random_traffic(20);
	endtask

	// Result side: random stall bursts, plus the long hold on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			stall_left = LONG_HOLD;
		end
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		lca_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual %b", $time, result);
			end else begin
				want = pending_results.pop_front();
				if (result.cell_alive !== want.cell_alive) begin
					error_count++;
					$display("%0t: cell_alive mismatch, expected %b actual %b",
						$time, want.cell_alive, result.cell_alive);
				end
				if (result.out_of_range !== want.out_of_range) begin
					error_count++;
					$display("%0t: out_of_range mismatch, expected %b actual %b",
						$time, want.out_of_range, result.out_of_range);
				end
			end
		end
	end

	initial begin
		while (cycle_count < MAX_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("life_cellular_automaton regression: fail");
		$finish;
	end

	initial begin
		item_valid <= 1'b0;
		item <= '0;
		foreach (live[r, c])
			live[r][c] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners_and_bounds();
		test_unused_op_and_step();
		test_blinker_at_border();
		test_random_traffic(40);
		test_backpressure();
		test_no_idle_tail();

		drain_results();
		repeat (lca_pkg::GRID_ROWS + 40) @(posedge clk);

		if (error_count == 0)
			$display("life_cellular_automaton regression: pass");
		else
			$display("life_cellular_automaton regression: fail");
		$finish;
	end

endmodule
